### rtl/lru_pr_pkg.sv
// lru_pr_pkg: shared types and fixed field widths for the lru page replacement block
// no dependencies; imported by lru_page_replacement_top
package lru_pr_pkg;

	// fixed widths of the port fields
	localparam int PAGE_NUM_W   = 16;
	localparam int SLOT_OUT_W   = 3;
	localparam int EVICT_PAGE_W = 16;
	localparam int FAULT_W      = 32;
	localparam int ACTIVE_W     = 4;

	// reset value of the active frame count register
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} lru_pr_state_t;

endpackage

### rtl/lru_page_replacement_top.sv
// lru_page_replacement_top: fully associative lru page frame table with a scanning sequencer
// depends on lru_pr_pkg and lru_pr_ram
// (frame pages live in one lru_pr_ram instance, recency ranks in flops)
//
// A reference word is taken on start while busy is low. The block then scans the
// active frames one per cycle through the frame ram and a single compare unit, looking
// for the page and at the same time tracking the least recently used frame. An update
// state follows, where on a miss the frame is filled or replaced; the target frame's
// rank is cleared and the ranks ahead of it age in parallel. The result word is shown
// for exactly one cycle with done high; it cannot be stalled, so the receiver must take
// it then. A new word is not taken before the last is done; eff, the active frame count
// clamped to 1..NUM_SLOTS, sets how many frames the scan reads. busy drops in the cycle
// done is high, so the next word may be started in that same cycle. The user must write
// active_slots through cfg_we / cfg_wdata only while busy is low; the block does not
// enforce this. 0 is taken as 1 and values above NUM_SLOTS as NUM_SLOTS. Frames beyond
// a lowered count keep their contents and come back into view when the count is raised.
// The fault count saturates at its maximum. No clearing pass is needed after reset.
module lru_page_replacement_top
	import lru_pr_pkg::*;
#(
	parameter int NUM_SLOTS = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// command side
	input  logic                    start,
	output logic                    busy,
	input  logic [PAGE_NUM_W-1:0]   page_number,
	// configuration
	input  logic                    cfg_we,
	input  logic [ACTIVE_W-1:0]     cfg_wdata,
	// result side
	output logic                    done,
	output logic                    hit,
	output logic [SLOT_OUT_W-1:0]   slot,
	output logic                    evicted_valid,
	output logic [EVICT_PAGE_W-1:0] evicted_page,
	output logic [FAULT_W-1:0]      fault_total
);

	localparam int IDX_W = $clog2(NUM_SLOTS);       // frame index
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);   // frame count, up to NUM_SLOTS

	// control state
	lru_pr_state_t        state_q;
	logic [ACTIVE_W-1:0]  active_q;
	logic [CNT_W-1:0]     eff_q;
	logic [CNT_W-1:0]     filled_q;
	logic [FAULT_W-1:0]   fault_q;
	logic [IDX_W-1:0]     rank_q [NUM_SLOTS];

	// scan pipeline: issue stage and compare stage
	logic                 issue_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 cmp_vld_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;

	// per-item working registers
	logic [PAGE_BITS-1:0] page_q;
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_slot_q;
	logic [IDX_W-1:0]     hit_rank_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic [IDX_W-1:0]     best_rank_q;
	logic [PAGE_BITS-1:0] best_page_q;

	// result registers
	logic                    done_q;
	logic                    hit_out_q;
	logic [SLOT_OUT_W-1:0]   slot_out_q;
	logic                    ev_valid_q;
	logic [EVICT_PAGE_W-1:0] ev_page_q;

	// ram ports
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [PAGE_BITS-1:0] ram_rdata;

	// combinational helpers
	logic                 accept;
	logic [CNT_W-1:0]     eff_next;
	logic [IDX_W-1:0]     last_idx;
	logic                 cmp_valid;
	logic                 cmp_match;
	logic [IDX_W-1:0]     cmp_rank;
	logic                 upd_fill;
	logic [IDX_W-1:0]     upd_slot;
	logic [IDX_W-1:0]     upd_limit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// clamp the active count to 1..NUM_SLOTS
	always_comb begin
		int e;
		e = int'(active_q);
		if (e < 1) begin
			e = 1;
		end
		if (e > NUM_SLOTS) begin
			e = NUM_SLOTS;
		end
		eff_next = CNT_W'(e);
	end

	assign last_idx = IDX_W'(eff_q - CNT_W'(1));

	// shared compare unit: one frame per cycle
	assign cmp_rank  = rank_q[cmp_idx_s1];
	assign cmp_valid = cmp_vld_s1 && (CNT_W'(cmp_idx_s1) < filled_q);
	assign cmp_match = cmp_valid && (ram_rdata == page_q);

	// update decision
	assign upd_fill  = !hit_q && (filled_q < eff_q);
	assign upd_slot  = hit_q ? hit_slot_q :
	                   (upd_fill ? filled_q[IDX_W-1:0] : best_slot_q);
	assign upd_limit = hit_q ? hit_rank_q : best_rank_q;

	assign ram_we    = (state_q == ST_UPDATE) && !hit_q;
	assign ram_waddr = upd_slot;

	lru_pr_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (NUM_SLOTS)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (page_q),
		.re    (issue_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			eff_q      <= '0;
			filled_q   <= '0;
			fault_q    <= '0;
			issue_q    <= 1'b0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			hit_q      <= 1'b0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eff_q      <= eff_next;
						idx_q      <= '0;
						issue_q    <= 1'b1;
						cmp_vld_s1 <= 1'b0;
						hit_q      <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue_q;
					if (issue_q) begin
						if (idx_q == last_idx) begin
							issue_q <= 1'b0;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (cmp_match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (cmp_valid && (!found_q || cmp_rank > best_rank_q)) begin
						found_q <= 1'b1;
					end
					if (cmp_vld_s1 && cmp_idx_s1 == last_idx) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// move the target frame to the front, age the ones ahead of it
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (IDX_W'(i) == upd_slot) begin
							rank_q[i] <= '0;
						end else if ((CNT_W'(i) < filled_q) &&
						             (upd_fill || rank_q[i] < upd_limit)) begin
							rank_q[i] <= rank_q[i] + IDX_W'(1);
						end
					end
					if (upd_fill) begin
						filled_q <= filled_q + CNT_W'(1);
					end
					if (!hit_q && fault_q != '1) begin
						fault_q <= fault_q + FAULT_W'(1);
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= PAGE_BITS'(page_number);
		end
		cmp_idx_s1 <= idx_q;
		if (state_q == ST_SCAN) begin
			if (cmp_match && !hit_q) begin
				hit_slot_q <= cmp_idx_s1;
				hit_rank_q <= cmp_rank;
			end
			if (cmp_valid && (!found_q || cmp_rank > best_rank_q)) begin
				best_slot_q <= cmp_idx_s1;
				best_rank_q <= cmp_rank;
				best_page_q <= ram_rdata;
			end
		end
		if (state_q == ST_UPDATE) begin
			hit_out_q  <= hit_q;
			slot_out_q <= SLOT_OUT_W'(upd_slot);
			ev_valid_q <= !hit_q && !upd_fill;
			ev_page_q  <= (!hit_q && !upd_fill) ? EVICT_PAGE_W'(best_page_q) : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_out_q;
	assign slot          = slot_out_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_q;

`ifndef SYNTH
	// a result word only follows an update cycle
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPDATE))
		else $error("result word without update cycle");

	// the fill count never passes the frame count
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(NUM_SLOTS) >= filled_q)
		else $error("fill count beyond frame count");

	// a replacement always has a victim from the scan
	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && !hit_q && !upd_fill) |-> found_q)
		else $error("replacement without victim");

	// the fault count moves only with a reported miss
	a_fault_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q != $past(fault_q)) |-> (done_q && !hit_out_q))
		else $error("fault count moved without a miss");

	// an eviction is never a hit
	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && ev_valid_q) |-> !hit_out_q)
		else $error("eviction reported on a hit");
`endif

endmodule

### rtl/lru_pr_ram.sv
// lru_pr_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the resident page of each frame
module lru_pr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
